/* hdl/rti_pkg.sv */
// Shared types and constants for the ray/triangle intersection core.
// Used by rti_div_step, ray_triangle_intersect_core, rti_checker and the testbench; no dependencies.
package rti_pkg;

	// Default coordinate format: signed Q11.10.
	localparam int COORD_BITS_DEF      = 21;
	localparam int COORD_FRAC_BITS_DEF = 10;

	// Packed vector field width and number of vector fields per item.
	localparam int FIELD_BITS = 63;
	localparam int NUM_FIELDS = 5;

	// Distance output format, unsigned Q16.16.
	localparam int DIST_BITS = 32;
	localparam int DIST_FRAC = 16;

	// Determinant threshold register, in Q.30 units.
	localparam int          EPS_BITS  = 32;
	localparam int          EPS_FRAC  = 30;
	localparam logic [31:0] EPS_RESET = 32'd1074;

	// Control group carried alongside each item through the divider stages.
	typedef struct packed {
		logic vld;
		logic hit;
		logic sat;
	} rti_ctl_t;

endpackage

/* hdl/rti_div_step.sv */
// One restoring-division stage: produces one quotient bit per item.
// Depends on rti_pkg for the control struct and the quotient width.
module rti_div_step #(
	parameter int W = 69
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  rti_pkg::rti_ctl_t             ctl_in,
	input  logic [W-1:0]                  det_in,
	input  logic [W-1:0]                  rem_in,
	input  logic [rti_pkg::DIST_BITS-1:0] quo_in,
	input  logic [rti_pkg::DIST_FRAC-1:0] nb_in,
	output rti_pkg::rti_ctl_t             ctl_out,
	output logic [W-1:0]                  det_out,
	output logic [W-1:0]                  rem_out,
	output logic [rti_pkg::DIST_BITS-1:0] quo_out,
	output logic [rti_pkg::DIST_FRAC-1:0] nb_out
);

	logic [W:0]   trial;
	logic         ge;
	logic [W-1:0] rem_nx;

	// Bring in the next numerator bit and try to subtract the divisor.
	always_comb begin
		trial  = {rem_in, nb_in[rti_pkg::DIST_FRAC-1]};
		ge     = (trial >= {1'b0, det_in});
		rem_nx = ge ? W'(trial - {1'b0, det_in}) : trial[W-1:0];
	end

	// Control travels with reset; payload needs none.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_out <= det_in;
			rem_out <= rem_nx;
			quo_out <= {quo_in[rti_pkg::DIST_BITS-2:0], ge};
			nb_out  <= {nb_in[rti_pkg::DIST_FRAC-2:0], 1'b0};
		end
	end

endmodule

/* hdl/ray_triangle_intersect_core.sv */
// Top level of the Moller-Trumbore ray/triangle intersection pipeline.
// Depends on rti_pkg and rti_div_step.
//
// Channel   Direction  Handshake          Contents
// s_*       in         s_tvalid/s_tready  origin, direction, three vertices
// m_*       out        m_tvalid/m_tready  hit flag, distance in Q16.16
// cfg_*     in         cfg_we             det_epsilon threshold
//
// One item enters per cycle while the output is not stalled; eight arithmetic stages
// (edges, cross products, split dot products, sums, sign fix, bound checks)
// followed by a 32-stage restoring divider, one quotient bit per stage.
// Reset clears all valid bits and loads det_epsilon with 1074.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module ray_triangle_intersect_core #(
	parameter int COORD_BITS      = rti_pkg::COORD_BITS_DEF,
	parameter int COORD_FRAC_BITS = rti_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// ray_origin, ray_direction, vertex_zero, vertex_one, vertex_two, zero pad
	input  logic [319:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// hit, hit_distance, zero pad
	output logic [39:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata
);

	localparam int CB  = COORD_BITS;
	localparam int D   = CB + 1;
	localparam int PW  = 2 * D + 1;
	localparam int LB  = PW / 2;
	localparam int HB  = PW - LB;
	localparam int W   = 3 * D + 3;
	localparam int EW  = W + 32;
	localparam int F3  = 3 * COORD_FRAC_BITS;
	localparam int SHE = (F3 >= rti_pkg::EPS_FRAC) ? F3 - rti_pkg::EPS_FRAC : 0;
	localparam int SHM = (F3 >= rti_pkg::EPS_FRAC) ? 0 : rti_pkg::EPS_FRAC - F3;
	localparam int NS  = rti_pkg::DIST_BITS;
	localparam int FB  = rti_pkg::FIELD_BITS;

	logic en;
	logic [rti_pkg::EPS_BITS-1:0] eps_q;

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= rti_pkg::EPS_RESET;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	// The pipeline advances whenever the output register can move.
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	rti_pkg::rti_ctl_t ctl_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// Unpack coordinates: x low, z high in each field.
	logic signed [CB-1:0] org [3];
	logic signed [CB-1:0] dir [3];
	logic signed [CB-1:0] v0  [3];
	logic signed [CB-1:0] v1  [3];
	logic signed [CB-1:0] v2  [3];

	logic signed [D-1:0] dir_s1 [3], e1_s1 [3], e2_s1 [3], sv_s1 [3];
	logic signed [D-1:0] dir_s2 [3], e1_s2 [3], e2_s2 [3], sv_s2 [3];
	logic signed [D-1:0] dir_s3 [3], e1_s3 [3], e2_s3 [3], sv_s3 [3];
	logic signed [2*D-1:0] pa_s2 [3], pb_s2 [3], qa_s2 [3], qb_s2 [3];
	logic signed [PW-1:0] p_s3 [3], q_s3 [3];

	for (genvar i = 0; i < 3; i++) begin : g_vec
		assign org[i] = s_tdata[0*FB + i*CB +: CB];
		assign dir[i] = s_tdata[1*FB + i*CB +: CB];
		assign v0[i]  = s_tdata[2*FB + i*CB +: CB];
		assign v1[i]  = s_tdata[3*FB + i*CB +: CB];
		assign v2[i]  = s_tdata[4*FB + i*CB +: CB];

		// Stage 1: edges and origin offset.
		always_ff @(posedge clk) begin
			if (en) begin
				dir_s1[i] <= D'(dir[i]);
				e1_s1[i]  <= D'(v1[i]) - D'(v0[i]);
				e2_s1[i]  <= D'(v2[i]) - D'(v0[i]);
				sv_s1[i]  <= D'(org[i]) - D'(v0[i]);
			end
		end

		// Stage 2: cross product terms, p = dir x e2 and q = s x e1.
		always_ff @(posedge clk) begin
			if (en) begin
				pa_s2[i] <= dir_s1[(i+1)%3] * e2_s1[(i+2)%3];
				pb_s2[i] <= dir_s1[(i+2)%3] * e2_s1[(i+1)%3];
				qa_s2[i] <= sv_s1[(i+1)%3] * e1_s1[(i+2)%3];
				qb_s2[i] <= sv_s1[(i+2)%3] * e1_s1[(i+1)%3];
				dir_s2[i] <= dir_s1[i];
				e1_s2[i]  <= e1_s1[i];
				e2_s2[i]  <= e2_s1[i];
				sv_s2[i]  <= sv_s1[i];
			end
		end

		// Stage 3: finish the cross products.
		always_ff @(posedge clk) begin
			if (en) begin
				p_s3[i]   <= PW'(pa_s2[i]) - PW'(pb_s2[i]);
				q_s3[i]   <= PW'(qa_s2[i]) - PW'(qb_s2[i]);
				dir_s3[i] <= dir_s2[i];
				e1_s3[i]  <= e1_s2[i];
				e2_s3[i]  <= e2_s2[i];
				sv_s3[i]  <= sv_s2[i];
			end
		end
	end

	// Stage 4: dot product terms, each wide factor split into two halves.
	// Index 0: det = e1.p, 1: U = s.p, 2: V = dir.q, 3: T = e2.q.
	logic signed [D+LB:0]  lo_s4 [4][3];
	logic signed [D+HB-1:0] hi_s4 [4][3];
	logic signed [W-1:0] tm_s5 [4][3];
	logic signed [W-1:0] sum_s6 [4];

	for (genvar i = 0; i < 3; i++) begin : g_dot
		logic signed [LB:0]   plo, qlo;
		logic signed [HB-1:0] phi, qhi;
		assign plo = $signed({1'b0, p_s3[i][LB-1:0]});
		assign qlo = $signed({1'b0, q_s3[i][LB-1:0]});
		assign phi = p_s3[i][PW-1:LB];
		assign qhi = q_s3[i][PW-1:LB];

		always_ff @(posedge clk) begin
			if (en) begin
				lo_s4[0][i] <= e1_s3[i] * plo;
				hi_s4[0][i] <= e1_s3[i] * phi;
				lo_s4[1][i] <= sv_s3[i] * plo;
				hi_s4[1][i] <= sv_s3[i] * phi;
				lo_s4[2][i] <= dir_s3[i] * qlo;
				hi_s4[2][i] <= dir_s3[i] * qhi;
				lo_s4[3][i] <= e2_s3[i] * qlo;
				hi_s4[3][i] <= e2_s3[i] * qhi;
			end
		end

		// Stage 5: recombine the halves of each term.
		for (genvar k = 0; k < 4; k++) begin : g_tm
			always_ff @(posedge clk) begin
				if (en) begin
					tm_s5[k][i] <= (W'(hi_s4[k][i]) <<< LB) + W'(lo_s4[k][i]);
				end
			end
		end
	end

	// Stage 6: sum the three terms of each dot product.
	for (genvar k = 0; k < 4; k++) begin : g_sum
		always_ff @(posedge clk) begin
			if (en) begin
				sum_s6[k] <= tm_s5[k][0] + tm_s5[k][1] + tm_s5[k][2];
			end
		end
	end

	// Stage 7: fold the determinant sign into all four values.
	logic signed [W-1:0] det_s7, u_s7, v_s7, t_s7;
	logic                zero_s7;
	logic                neg;

	assign neg = sum_s6[0][W-1];

	always_ff @(posedge clk) begin
		if (en) begin
			det_s7  <= neg ? -sum_s6[0] : sum_s6[0];
			u_s7    <= neg ? -sum_s6[1] : sum_s6[1];
			v_s7    <= neg ? -sum_s6[2] : sum_s6[2];
			t_s7    <= neg ? -sum_s6[3] : sum_s6[3];
			zero_s7 <= (sum_s6[0] == '0);
		end
	end

	// Stage 8: threshold, barycentric bounds, distance sign and saturation.
	logic [EW-1:0]        mag_x, eps_x;
	logic signed [W:0]    uv_sum;
	logic signed [W+16:0] det_sh;
	logic                 hit_c, sat_c;

	always_comb begin
		mag_x  = EW'(det_s7) << SHM;
		eps_x  = EW'(eps_q) << SHE;
		uv_sum = (W+1)'(u_s7) + (W+1)'(v_s7);
		det_sh = (W+17)'(det_s7) <<< rti_pkg::DIST_FRAC;
		hit_c  = !zero_s7 && (mag_x >= eps_x) &&
		         !u_s7[W-1] && !(u_s7 > det_s7) &&
		         !v_s7[W-1] && !(uv_sum > (W+1)'(det_s7)) &&
		         !t_s7[W-1];
		sat_c  = ((W+17)'(t_s7) >= det_sh);
	end

	logic [W-1:0]                  det_s8, rem_s8;
	logic [rti_pkg::DIST_FRAC-1:0] nb_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s8 <= '0;
		end else if (en) begin
			ctl_s8 <= '{vld: vld_s7, hit: hit_c, sat: sat_c};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s8 <= det_s7;
			rem_s8 <= W'(t_s7 >>> rti_pkg::DIST_FRAC);
			nb_s8  <= t_s7[rti_pkg::DIST_FRAC-1:0];
		end
	end

	// Divider: one quotient bit per stage.
	rti_pkg::rti_ctl_t             ctl_d [NS+1];
	logic [W-1:0]                  det_d [NS+1];
	logic [W-1:0]                  rem_d [NS+1];
	logic [NS-1:0]                 quo_d [NS+1];
	logic [rti_pkg::DIST_FRAC-1:0] nb_d  [NS+1];

	assign ctl_d[0] = ctl_s8;
	assign det_d[0] = det_s8;
	assign rem_d[0] = rem_s8;
	assign quo_d[0] = '0;
	assign nb_d[0]  = nb_s8;

	for (genvar j = 0; j < NS; j++) begin : g_div
		rti_div_step #(.W(W)) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl_in  (ctl_d[j]),
			.det_in  (det_d[j]),
			.rem_in  (rem_d[j]),
			.quo_in  (quo_d[j]),
			.nb_in   (nb_d[j]),
			.ctl_out (ctl_d[j+1]),
			.det_out (det_d[j+1]),
			.rem_out (rem_d[j+1]),
			.quo_out (quo_d[j+1]),
			.nb_out  (nb_d[j+1])
		);
	end

	// Output: saturate far hits, zero the distance on a miss.
	logic [NS-1:0] dist_c;

	always_comb begin
		if (!ctl_d[NS].hit) begin
			dist_c = '0;
		end else if (ctl_d[NS].sat) begin
			dist_c = '1;
		end else begin
			dist_c = quo_d[NS];
		end
	end

	assign m_tvalid = ctl_d[NS].vld;
	assign m_tdata  = {7'b0, dist_c, ctl_d[NS].hit};

endmodule

/* sim/rti_checker.sv */
// Scoreboard for the ray/triangle intersection core: predicts each test and checks the output.
// Depends on rti_pkg. It watches the input, output and configuration ports without driving them.
module rti_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [319:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [39:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,
	output int           fail_count,
	output int           pending
);

	localparam int CB = rti_pkg::COORD_BITS_DEF;
	localparam int FB = rti_pkg::COORD_FRAC_BITS_DEF;

	typedef logic signed [127:0] wide_t;

	// Expected {distance, hit} pairs, oldest first.
	logic [32:0] hit_queue[$];
	logic [31:0] threshold;
	int          mismatches;

	// Pull one signed coordinate out of the packed item.
	function automatic wide_t coord(input logic [319:0] d, input int fld, input int axis);
		logic [CB-1:0] raw;
		raw = d[fld*rti_pkg::FIELD_BITS + axis*CB +: CB];
		return wide_t'($signed(raw));
	endfunction

	// Exact Moller-Trumbore test; returns {hit_distance, hit}.
	function automatic logic [32:0] intersect_test(input logic [319:0] d, input logic [31:0] eps);
		wide_t org[3], dir[3], v0[3], v1[3], v2[3];
		wide_t e1[3], e2[3], s[3], p[3], q[3];
		wide_t det, un, vn, tn, mag, lim;
		logic [31:0] distance;
		for (int i = 0; i < 3; i++) begin
			org[i] = coord(d, 0, i);
			dir[i] = coord(d, 1, i);
			v0[i]  = coord(d, 2, i);
			v1[i]  = coord(d, 3, i);
			v2[i]  = coord(d, 4, i);
			e1[i]  = v1[i] - v0[i];
			e2[i]  = v2[i] - v0[i];
			s[i]   = org[i] - v0[i];
		end
		p[0] = dir[1] * e2[2] - dir[2] * e2[1];
		p[1] = dir[2] * e2[0] - dir[0] * e2[2];
		p[2] = dir[0] * e2[1] - dir[1] * e2[0];
		q[0] = s[1] * e1[2] - s[2] * e1[1];
		q[1] = s[2] * e1[0] - s[0] * e1[2];
		q[2] = s[0] * e1[1] - s[1] * e1[0];
		det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
		un  = s[0] * p[0] + s[1] * p[1] + s[2] * p[2];
		vn  = dir[0] * q[0] + dir[1] * q[1] + dir[2] * q[2];
		tn  = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
		if (det == 0)
			return 33'd0;
		// A negative determinant flips every term so the bounds use a positive det.
		if (det < 0) begin
			det = -det;
			un  = -un;
			vn  = -vn;
			tn  = -tn;
		end
		mag = det;
		lim = wide_t'({96'd0, eps});
		if (3 * FB >= rti_pkg::EPS_FRAC)
			lim = lim <<< (3 * FB - rti_pkg::EPS_FRAC);
		else
			mag = mag <<< (rti_pkg::EPS_FRAC - 3 * FB);
		if (mag < lim)
			return 33'd0;
		if (un < 0 || un > det || vn < 0 || un + vn > det || tn < 0)
			return 33'd0;
		if (tn >= (det <<< rti_pkg::DIST_FRAC))
			distance = '1;
		else
			distance = 32'((tn <<< rti_pkg::DIST_FRAC) / det);
		return {distance, 1'b1};
	endfunction

	// Track the threshold, queue predictions and compare results.
	always @(posedge clk or negedge arst_n) begin
		logic [32:0] want;
		logic [32:0] got;
		if (!arst_n) begin
			threshold = rti_pkg::EPS_RESET;
			hit_queue.delete();
			fail_count = 0;
			mismatches = 0;
			pending = 0;
		end else begin
			if (s_tvalid && s_tready)
				hit_queue.insert(hit_queue.size(), intersect_test(s_tdata, threshold));
			if (cfg_we)
				threshold = cfg_wdata;
			if (m_tvalid && m_tready) begin
				got = m_tdata[32:0];
				if (hit_queue.size() == 0) begin
					fail_count++;
					if (mismatches++ < 10)
						$display("unexpected item: hit=%0b dist=%h", got[0], got[32:1]);
				end else begin
					want = hit_queue.pop_front();
					if (want[0] !== got[0] || want[32:1] !== got[32:1]) begin
						fail_count++;
						if (mismatches++ < 10)
							$display("mismatch: expected hit=%0b dist=%h, got hit=%0b dist=%h",
								want[0], want[32:1], got[0], got[32:1]);
					end
				end
			end
			pending = hit_queue.size();
		end
	end

endmodule

/* sim/ray_triangle_intersect_core_tb.sv */
// Testbench top for ray_triangle_intersect_core: clock, reset, stimulus and verdict.
// Depends on rti_pkg, the core and the rti_checker scoreboard.
module ray_triangle_intersect_core_tb;

	localparam int LATENCY = 40;
	localparam int ONE = 1 << rti_pkg::COORD_FRAC_BITS_DEF;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [319:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [39:0]  m_tdata;
	logic         cfg_we = 1'b0;
	logic [31:0]  cfg_wdata = '0;
	int           fail_count;
	int           pending;

	// Receiver control: a long hold-off request and the end-of-run quiet flag.
	int hold_cycles = 0;
	bit quiet = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	ray_triangle_intersect_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	rti_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending)
	);

	// Pack three coordinates, x in the low bits.
	function automatic logic [62:0] vec(input int x, input int y, input int z);
		logic [20:0] xs, ys, zs;
		xs = x[20:0];
		ys = y[20:0];
		zs = z[20:0];
		return {zs, ys, xs};
	endfunction

	function automatic logic [319:0] test_item(input logic [62:0] org, input logic [62:0] dir,
			input logic [62:0] v0, input logic [62:0] v1, input logic [62:0] v2);
		return {5'd0, v2, v1, v0, dir, org};
	endfunction

	function automatic int rnd(input int span);
		return $urandom_range(0, 2 * span) - span;
	endfunction

	// Offer one item and hold it until the core takes it.
	task automatic send_test(input logic [319:0] d);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Write the threshold once the pipeline has drained.
	task automatic write_threshold(input logic [31:0] value);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// A ray aimed through a random point of a random triangle, with assorted twists.
	function automatic logic [319:0] random_test();
		int v0[3], v1[3], v2[3], org[3], dir[3];
		int wa, wb, n, kind, sh;
		n = 256;
		wa = $urandom_range(0, n);
		wb = $urandom_range(0, n - wa);
		kind = $urandom_range(0, 19);
		sh = $urandom_range(0, 3);
		for (int i = 0; i < 3; i++) begin
			v0[i] = rnd(1 << 14);
			v1[i] = rnd(1 << 14);
			v2[i] = rnd(1 << 14);
			org[i] = rnd(1 << 14);
			dir[i] = v0[i] + ((v1[i] - v0[i]) * wa + (v2[i] - v0[i]) * wb) / n - org[i];
			dir[i] = $urandom_range(0, 1) ? dir[i] >>> sh : dir[i] <<< (sh >> 1);
		end
		// Raw random items keep the pad bits above the five fields at zero.
		if (kind < 2)
			return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom(), $urandom(), $urandom()} &
				{5'd0, {315{1'b1}}};
		if (kind < 4)
			for (int i = 0; i < 3; i++)
				dir[i] = -dir[i];
		if (kind == 4)
			for (int i = 0; i < 3; i++)
				dir[i] = rnd(8);
		return test_item(vec(org[0], org[1], org[2]), vec(dir[0], dir[1], dir[2]),
			vec(v0[0], v0[1], v0[2]), vec(v1[0], v1[1], v1[2]), vec(v2[0], v2[1], v2[2]));
	endfunction

	// Directed cases, most on the unit triangle in the z = 0 plane.
	task automatic directed_tests();
		logic [62:0] a, b, c, down;
		a = vec(0, 0, 0);
		b = vec(ONE, 0, 0);
		c = vec(0, ONE, 0);
		down = vec(0, 0, ONE);
		send_test('0);
		send_test({5'd0, {315{1'b1}}});
		send_test(test_item(vec(ONE / 4, ONE / 4, -ONE), down, a, b, c));
		send_test(test_item(vec(ONE / 4, ONE / 4, -ONE), down, a, c, b));
		send_test(test_item(vec(0, 0, -ONE), down, a, b, c));
		send_test(test_item(vec(ONE, 0, -ONE), down, a, b, c));
		send_test(test_item(vec(0, ONE, -ONE), down, a, b, c));
		send_test(test_item(vec(ONE / 2, ONE / 2, -ONE), down, a, b, c));
		send_test(test_item(vec(ONE + 1, 0, -ONE), down, a, b, c));
		send_test(test_item(vec(-1, 0, -ONE), down, a, b, c));
		send_test(test_item(vec(0, -1, -ONE), down, a, b, c));
		send_test(test_item(vec(ONE / 2 + 1, ONE / 2, -ONE), down, a, b, c));
		send_test(test_item(vec(ONE / 4, ONE / 4, 0), down, a, b, c));
		send_test(test_item(vec(ONE / 4, ONE / 4, ONE), down, a, b, c));
		send_test(test_item(vec(ONE / 4, ONE / 4, -(1 << 20)), vec(0, 0, 1), a, b, c));
		send_test(test_item(vec(ONE / 4, ONE / 4, -ONE), vec(ONE, 0, 0), a, b, c));
		send_test(test_item(vec(ONE / 4, ONE / 4, -ONE), vec(0, 0, 3), a, b, c));
		send_test(test_item(vec(0, 0, -(1 << 20)), vec(0, 0, (1 << 20) - 1),
			vec(-(1 << 20), -(1 << 20), 0), vec((1 << 20) - 1, -(1 << 20), 0),
			vec(-(1 << 20), (1 << 20) - 1, 0)));
		send_test(test_item(vec(-(1 << 20), -(1 << 20), -(1 << 20)),
			vec((1 << 20) - 1, (1 << 20) - 1, (1 << 20) - 1), a, b, c));
	endtask

	// Receiver: random stall bursts, a requested long hold-off, none when quiet.
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				stall = $urandom_range(0, 3);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Main sequence.
	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset threshold first, then the extremes and a few values between.
		directed_tests();
		write_threshold(32'd0);
		directed_tests();
		write_threshold(32'hFFFF_FFFF);
		directed_tests();
		hold_cycles = 150;
		repeat (200) send_test(random_test());
		write_threshold($urandom_range(1, 1 << 20));
		repeat (400) send_test(random_test());
		write_threshold(32'd1);
		repeat (300) send_test(random_test());
		write_threshold(rti_pkg::EPS_RESET);
		quiet = 1'b1;
		repeat (300) send_test(random_test());
		s_tvalid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (fail_count == 0)
			$display("ray_triangle_intersect_core regression: pass");
		else
			$display("ray_triangle_intersect_core regression: fail");
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("ray_triangle_intersect_core regression: fail");
		$finish;
	end

endmodule
